FILE: sv/bgsd_pkg.sv
`timescale 1ns / 1ps

package bgsd_pkg;

	typedef logic [3:0] geno_t;
	typedef logic [2:0] vcount_t;
	typedef logic [1:0] status_t;
	typedef logic [1:0] hdr_pos_t;

	// header byte values
	localparam logic [7:0] MAGIC_FIRST    = 8'h6C;
	localparam logic [7:0] MAGIC_SECOND   = 8'h1B;
	localparam logic [7:0] MODE_SNP_MAJOR = 8'h01;

	// header positions
	localparam hdr_pos_t HDR_MAGIC0 = 2'd0;
	localparam hdr_pos_t HDR_MAGIC1 = 2'd1;
	localparam hdr_pos_t HDR_MODE   = 2'd2;
	localparam hdr_pos_t HDR_DONE   = 2'd3;

	// status codes
	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_BAD_MAGIC = 2'd1;
	localparam status_t STATUS_BAD_MODE  = 2'd2;

	// 2-bit code values
	localparam logic [1:0] CODE_HOM_A    = 2'b00;
	localparam logic [1:0] CODE_MISSING  = 2'b01;
	localparam logic [1:0] CODE_HET      = 2'b10;
	localparam logic [1:0] CODE_HOM_B    = 2'b11;

	localparam geno_t GENO_MISSING = 4'd9;
	localparam vcount_t GENOS_PER_BYTE = 3'd4;

	// map one packed code to its genotype value
	function automatic geno_t code_to_geno(input logic [1:0] code);
		geno_t g;
		case (code)
			CODE_HOM_A:   g = 4'd0;
			CODE_MISSING: g = GENO_MISSING;
			CODE_HET:     g = 4'd1;
			CODE_HOM_B:   g = 4'd2;
			default:      g = 4'd0;
		endcase
		return g;
	endfunction

endpackage

FILE: sv/bgsd_if.sv
`timescale 1ns / 1ps

// raw byte stream
interface bgsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// decoded genotype results
interface bgsd_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] geno_a;
	logic [3:0] geno_b;
	logic [3:0] geno_c;
	logic [3:0] geno_d;
	logic [2:0] valid_count;
	logic       block_end;
	logic [1:0] status;

	modport source (output valid, output geno_a, output geno_b, output geno_c,
		output geno_d, output valid_count, output block_end, output status,
		input ready);
	modport sink   (input valid, input geno_a, input geno_b, input geno_c,
		input geno_d, input valid_count, input block_end, input status,
		output ready);
endinterface

// sample count register write
interface bgsd_cfg_if #(parameter int SAMPLE_BITS = 20);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample_count;

	modport source (output valid, output sample_count, input ready);
	modport sink   (input valid, input sample_count, output ready);
endinterface

FILE: sv/bed_genotype_stream_decoder_top.sv
`timescale 1ns / 1ps
// channel | interface    | payload
// --------+--------------+--------------------------------------------------------
// cfg     | bgsd_cfg_if  | sample_count (SAMPLE_BITS), always ready
// bytes   | bgsd_in_if   | data_byte (8)
// genos   | bgsd_out_if  | geno_a..geno_d (4 each), valid_count (3), block_end, status
//
// one byte per cycle sustained while genos is not stalled; each byte passes
// through the input register into the result register, with header and block
// state updated as the byte moves from the input to the result register.
// reset clears the header position, sticky error, block position and both valid
// bits, and sets the sample count to 1.
// a stall on genos holds the result; the input register still takes a byte while
// it is empty or the result register is empty or draining.

module bed_genotype_stream_decoder_top #(
	parameter int SAMPLE_BITS = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	bgsd_cfg_if.sink   cfg,
	bgsd_in_if.sink    bytes,
	bgsd_out_if.source genos
);
	import bgsd_pkg::*;

	logic [SAMPLE_BITS-1:0] sample_count_q;
	logic [SAMPLE_BITS-1:0] sample_pos_q;
	hdr_pos_t               header_pos_q;
	status_t                error_q;

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic    valid_s2;
	geno_t   geno_s2 [4];
	vcount_t valid_count_s2;
	logic    block_end_s2;
	status_t status_s2;

	logic adv_s2;
	logic take_s1;

	logic                   hdr_active;
	status_t                error_next;
	logic [SAMPLE_BITS:0]   remain_diff;
	logic                   remain_neg;
	logic                   last_byte;
	vcount_t                valid_count;
	logic [SAMPLE_BITS-1:0] sample_pos_next;
	geno_t                  geno_dec [4];

	// flow control
	assign adv_s2     = !valid_s2 || genos.ready;
	assign take_s1    = valid_s1 && adv_s2;
	assign bytes.ready = !valid_s1 || adv_s2;
	assign cfg.ready  = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_BITS'(1);
		end else if (cfg.valid) begin
			sample_count_q <= cfg.sample_count;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.data_byte;
		end
	end

	// header check, error 2 overrides error 1
	assign hdr_active = (header_pos_q != HDR_DONE);

	always_comb begin
		error_next = error_q;
		case (header_pos_q)
			HDR_MAGIC0: begin
				if (byte_s1 != MAGIC_FIRST && error_q == STATUS_OK) begin
					error_next = STATUS_BAD_MAGIC;
				end
			end
			HDR_MAGIC1: begin
				if (byte_s1 != MAGIC_SECOND && error_q == STATUS_OK) begin
					error_next = STATUS_BAD_MAGIC;
				end
			end
			HDR_MODE: begin
				if (byte_s1 != MODE_SNP_MAJOR) begin
					error_next = STATUS_BAD_MODE;
				end
			end
			default: error_next = error_q;
		endcase
	end

	// remaining samples in the block, clamped at zero
	assign remain_diff = {1'b0, sample_count_q} - {1'b0, sample_pos_q};
	assign remain_neg  = remain_diff[SAMPLE_BITS];
	assign last_byte   = remain_neg ||
		(remain_diff[SAMPLE_BITS-1:0] <= SAMPLE_BITS'(GENOS_PER_BYTE));

	always_comb begin
		if (hdr_active || remain_neg) begin
			valid_count = '0;
		end else if (last_byte) begin
			valid_count = remain_diff[2:0];
		end else begin
			valid_count = GENOS_PER_BYTE;
		end
	end

	assign sample_pos_next = last_byte ? '0 :
		sample_pos_q + SAMPLE_BITS'(GENOS_PER_BYTE);

	bgsd_unpack u_unpack (
		.data_byte   (byte_s1),
		.valid_count (valid_count),
		.geno        (geno_dec)
	);

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_pos_q <= HDR_MAGIC0;
			error_q      <= STATUS_OK;
			sample_pos_q <= '0;
		end else if (take_s1) begin
			if (hdr_active) begin
				header_pos_q <= header_pos_q + 2'd1;
				error_q      <= error_next;
			end else begin
				sample_pos_q <= sample_pos_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			geno_s2        <= geno_dec;
			valid_count_s2 <= valid_count;
			block_end_s2   <= !hdr_active && last_byte;
			status_s2      <= hdr_active ? error_next : error_q;
		end
	end

	assign genos.valid       = valid_s2;
	assign genos.geno_a      = geno_s2[0];
	assign genos.geno_b      = geno_s2[1];
	assign genos.geno_c      = geno_s2[2];
	assign genos.geno_d      = geno_s2[3];
	assign genos.valid_count = valid_count_s2;
	assign genos.block_end   = block_end_s2;
	assign genos.status      = status_s2;

endmodule

FILE: sv/bgsd_unpack.sv
`timescale 1ns / 1ps

module bgsd_unpack (
	input  logic [7:0]         data_byte,
	input  bgsd_pkg::vcount_t  valid_count,
	output bgsd_pkg::geno_t    geno [4]
);
	import bgsd_pkg::*;

	// four independent lanes, least significant pair first; unused slots read zero
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < valid_count) begin
				geno[i] = code_to_geno(data_byte[2*i +: 2]);
			end else begin
				geno[i] = '0;
			end
		end
	end

endmodule

FILE: sv/bgsd_checker.sv
`timescale 1ns / 1ps

module bgsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] geno_a,
	input logic [3:0] geno_b,
	input logic [3:0] geno_c,
	input logic [3:0] geno_d,
	input logic [2:0] valid_count,
	input logic       block_end,
	input logic [1:0] status
);
	import bgsd_pkg::*;

	logic out_acc;
	logic seen_err_q;
	logic seen_mode_q;

	assign out_acc = out_valid && out_ready;

	// track errors already reported on delivered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_err_q  <= 1'b0;
			seen_mode_q <= 1'b0;
		end else if (out_acc) begin
			if (status != STATUS_OK) begin
				seen_err_q <= 1'b1;
			end
			if (status == STATUS_BAD_MODE) begin
				seen_mode_q <= 1'b1;
			end
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({geno_a, geno_b, geno_c,
		geno_d, valid_count, block_end, status}))
		else $error("result changed while stalled");

	// a short byte is only the end of a block or a header byte
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !block_end && valid_count != GENOS_PER_BYTE |-> valid_count == 3'd0)
		else $error("partial byte without block end");

	// no genotype shown when none is valid
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_count == 3'd0 |->
		geno_a == 4'd0 && geno_b == 4'd0 && geno_c == 4'd0 && geno_d == 4'd0)
		else $error("genotype present with zero valid count");

	// errors stay once reported
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_err_q |-> status != STATUS_OK)
		else $error("sticky error cleared");

	// bad mode is never replaced
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_mode_q |-> status == STATUS_BAD_MODE)
		else $error("bad mode status replaced");

endmodule

bind bed_genotype_stream_decoder_top bgsd_checker u_bgsd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (genos.valid),
	.out_ready   (genos.ready),
	.geno_a      (genos.geno_a),
	.geno_b      (genos.geno_b),
	.geno_c      (genos.geno_c),
	.geno_d      (genos.geno_d),
	.valid_count (genos.valid_count),
	.block_end   (genos.block_end),
	.status      (genos.status)
);
